/* hdl/mtg_pkg.sv */
// ----------------------------------------------------------------------------
// mtg_pkg
// Types and constants shared by the generator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package mtg_pkg;

  localparam int unsigned StoreLen = 624;
  localparam int unsigned ShiftPos = 397;
  localparam int unsigned IdxW     = 10;

  localparam logic [31:0] TwistMat    = 32'h9908B0DF;
  localparam logic [31:0] TemperB     = 32'h9D2C5680;
  localparam logic [31:0] TemperC     = 32'hEFC60000;
  localparam logic [31:0] SeedMul     = 32'd69069;
  localparam logic [31:0] DefaultSeed = 32'd4357;
  localparam logic [31:0] UpperBit    = 32'h80000000;
  localparam logic [31:0] LowerBits   = 32'h7FFFFFFF;

  localparam logic [1:0] CmdSeed   = 2'd0;
  localparam logic [1:0] CmdDraw   = 2'd1;
  localparam logic [1:0] CmdRanged = 2'd2;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load_in;    // capture input fields
    logic       fill_start; // load first seed word (use_default selects default seed)
    logic       use_default;
    logic       fill_step;  // write one seed word, advance
    logic       tw_rd0;     // twist: issue read of word i
    logic       tw_rd1;     // twist: issue read of word i+1
    logic       tw_rd2;     // twist: issue read of word i+397
    logic       tw_wr;      // twist: write word i, advance
    logic       tw_start;   // clear twist pointer
    logic       dr_rd;      // draw: read word at index
    logic       dr_temper;  // draw: temper read data
    logic       mod_start;  // start remainder unit
    logic       mod_step;   // one remainder bit
    logic       finish;     // produce result
    logic       zero_out;   // result is zero
  } mtg_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic fill_done;
    logic tw_done;
    logic mod_done;
    logic exhausted;
  } mtg_stat_t;

endpackage
`default_nettype wire

/* hdl/mersenne_twister_generator.sv */
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator with odd-start 69069 seeding and ranged draws.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A draw reads
// and tempers one stored word, then registers the result; a ranged draw
// with a nonzero high adds the bit-serial remainder. A seed makes one
// store write per word. Every 624th draw first twists the store, three
// reads on the single read port then one write per word; a draw before
// any seed also fills first. Results appear for one cycle with strobe
// high and cannot be held off.
`default_nettype none
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] seed_value,
  input  wire logic [31:0] range_low,
  input  wire logic [31:0] range_high,
  output logic             strobe,
  output logic [31:0]      random_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  mtg_cmd_t  cmd;
  mtg_stat_t stat;
  logic      enabled;
  logic      ranged;

  // Hold the enable register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) enabled <= 1'b1;
    else if (cfg_valid) enabled <= cfg_data[0];
  end

  mtg_control u_ctrl (
    .clk, .rst, .start, .command, .enabled, .stat, .ranged,
    .busy, .cmd, .strobe
  );

  mtg_datapath u_dp (
    .clk, .rst, .cmd, .stat, .command, .seed_value, .range_low,
    .range_high, .random_word, .ranged
  );

endmodule
`default_nettype wire

/* hdl/mtg_datapath.sv */
// ----------------------------------------------------------------------------
// mtg_datapath
// Word store, seed multiplier, twist, tempering and a bit-serial remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module mtg_datapath
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mtg_cmd_t    cmd,
  output mtg_stat_t        stat,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] seed_value,
  input  wire logic [31:0] range_low,
  input  wire logic [31:0] range_high,
  output logic [31:0]      random_word,
  output logic             ranged
);

  logic [31:0] mem [StoreLen];
  logic [31:0] rd_data;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;

  logic [1:0]  cmd_q;
  logic [31:0] seed_q, low_q, high_q;
  logic [IdxW-1:0] ptr;       // fill and twist pointer
  logic [IdxW-1:0] word_index;
  logic [31:0] x;             // running seed word
  logic [31:0] w_cur, w_nxt;  // twist operands
  logic [31:0] y;             // tempered word
  logic [31:0] rem;
  logic [31:0] quo_src;
  logic [5:0]  bit_cnt;

  // Wrapped neighbor addresses of the twist pointer.
  logic [IdxW-1:0] ptr_p1, ptr_pm;
  logic [IdxW:0]   sum_m;
  always_comb begin
    ptr_p1 = (ptr == IdxW'(StoreLen - 1)) ? '0 : ptr + 1'b1;
    sum_m  = {1'b0, ptr} + (IdxW+1)'(ShiftPos);
    ptr_pm = (sum_m >= (IdxW+1)'(StoreLen)) ?
             IdxW'(sum_m - (IdxW+1)'(StoreLen)) : sum_m[IdxW-1:0];
  end

  // Select read address.
  always_comb begin
    rd_addr = word_index;
    if (cmd.tw_rd0) rd_addr = ptr;
    if (cmd.tw_rd1) rd_addr = ptr_p1;
    if (cmd.tw_rd2) rd_addr = ptr_pm;
  end

  // Twist result for the current pointer; rd_data holds word i+397.
  logic [31:0] tw_y, tw_v;
  always_comb begin
    tw_y = (w_cur & UpperBit) | (w_nxt & LowerBits);
    tw_v = rd_data ^ (tw_y >> 1);
    if (w_nxt[0]) tw_v = tw_v ^ TwistMat;
  end

  // Select write.
  always_comb begin
    wr_en   = cmd.fill_step || cmd.tw_wr;
    wr_addr = ptr;
    wr_data = cmd.tw_wr ? tw_v : x;
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Temper chain.
  logic [31:0] t1, t2, t3, t4;
  always_comb begin
    t1 = rd_data ^ (rd_data >> 11);
    t2 = t1 ^ ((t1 << 7) & TemperB);
    t3 = t2 ^ ((t2 << 15) & TemperC);
    t4 = t3 ^ (t3 >> 18);
  end

  // Trial subtract for the remainder unit.
  logic [32:0] trial;
  logic [31:0] rem_sh;
  always_comb begin
    rem_sh = {rem[30:0], quo_src[31]};
    trial  = {rem[31], rem_sh} - {1'b0, high_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= IdxW'(StoreLen);
      ptr        <= '0;
      bit_cnt    <= '0;
    end else begin
      // Capture transaction fields.
      if (cmd.load_in) begin
        cmd_q  <= command;
        seed_q <= seed_value;
        low_q  <= range_low;
        high_q <= range_high;
      end
      // Seeding.
      if (cmd.fill_start) begin
        x   <= (cmd.use_default ? DefaultSeed : seed_q) | 32'd1;
        ptr <= '0;
      end
      if (cmd.fill_step) begin
        x   <= x * SeedMul;
        ptr <= ptr_p1;
        if (ptr == IdxW'(StoreLen - 1)) word_index <= IdxW'(StoreLen);
      end
      // Twisting.
      if (cmd.tw_start) ptr <= '0;
      if (cmd.tw_rd1) w_cur <= rd_data;
      if (cmd.tw_rd2) w_nxt <= rd_data;
      if (cmd.tw_wr) begin
        ptr <= ptr_p1;
        if (ptr == IdxW'(StoreLen - 1)) word_index <= '0;
      end
      // Drawing.
      if (cmd.dr_temper) begin
        y          <= t4;
        word_index <= word_index + 1'b1;
      end
      // Remainder: restoring, one bit a cycle.
      if (cmd.mod_start) begin
        rem     <= '0;
        quo_src <= y;
        bit_cnt <= 6'd32;
      end
      if (cmd.mod_step) begin
        quo_src <= {quo_src[30:0], 1'b0};
        bit_cnt <= bit_cnt - 1'b1;
        if (!trial[32]) rem <= trial[31:0];
        else            rem <= rem_sh;
      end
      if (cmd.finish) begin
        if (cmd.zero_out)                random_word <= '0;
        else if (cmd_q != CmdRanged)     random_word <= y;
        else if (high_q == '0)           random_word <= y + low_q;
        else                             random_word <= rem + low_q;
      end
    end
  end

  always_comb begin
    stat.fill_done = (ptr == IdxW'(StoreLen - 1));
    stat.tw_done   = (ptr == IdxW'(StoreLen - 1));
    stat.mod_done  = (bit_cnt == 6'd1);
    stat.exhausted = (word_index >= IdxW'(StoreLen));
    ranged         = (cmd_q == CmdRanged) && (high_q != '0);
  end

endmodule
`default_nettype wire

/* hdl/mtg_control.sv */
// ----------------------------------------------------------------------------
// mtg_control
// Sequencer for seed, twist, draw and remainder steps.
// ----------------------------------------------------------------------------
`default_nettype none
module mtg_control
  import mtg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] command,
  input  wire logic       enabled,
  input  wire mtg_stat_t  stat,
  input  wire logic       ranged,
  output logic            busy,
  output mtg_cmd_t        cmd,
  output logic            strobe
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_FILL = 4'd2;
  localparam logic [3:0] S_TW0  = 4'd3;
  localparam logic [3:0] S_TW1  = 4'd4;
  localparam logic [3:0] S_TW2  = 4'd5;
  localparam logic [3:0] S_TW3  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_TMP  = 4'd8;
  localparam logic [3:0] S_MOD0 = 4'd9;
  localparam logic [3:0] S_MOD  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_ZERO = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] cmd_r;
  logic       seeded, is_draw;

  always_comb begin
    state_next = state;
    cmd = '0;
    is_draw = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        if (cmd_r == CmdSeed) begin
          if (enabled) begin
            cmd.fill_start = 1'b1;
            state_next = S_FILL;
          end else begin
            state_next = S_IDLE;
          end
        end else if (cmd_r == CmdDraw || cmd_r == CmdRanged) begin
          if (!enabled) state_next = S_ZERO;
          else if (stat.exhausted && !seeded) begin
            cmd.fill_start  = 1'b1;
            cmd.use_default = 1'b1;
            state_next = S_FILL;
          end else if (stat.exhausted) begin
            cmd.tw_start = 1'b1;
            state_next = S_TW0;
          end else begin
            state_next = S_RD;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        is_draw = (cmd_r != CmdSeed);
        // The pointer wraps to zero on the last word, ready for the twist.
        if (stat.fill_done) begin
          if (is_draw) begin
            state_next = S_TW0;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      // Three reads then a write per twisted word.
      S_TW0: begin cmd.tw_rd0 = 1'b1; state_next = S_TW1; end
      S_TW1: begin cmd.tw_rd1 = 1'b1; state_next = S_TW2; end
      S_TW2: begin cmd.tw_rd2 = 1'b1; state_next = S_TW3; end
      S_TW3: begin
        cmd.tw_wr = 1'b1;
        state_next = stat.tw_done ? S_RD : S_TW0;
      end
      S_RD: begin
        cmd.dr_rd = 1'b1;
        state_next = S_TMP;
      end
      S_TMP: begin
        cmd.dr_temper = 1'b1;
        state_next = ranged ? S_MOD0 : S_FIN;
      end
      S_MOD0: begin
        cmd.mod_start = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_ZERO: begin
        cmd.finish   = 1'b1;
        cmd.zero_out = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      seeded <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.finish;
      if (cmd.fill_start) seeded <= 1'b1;
      if (cmd.load_in) cmd_r <= command;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire
